/* sv/uv_sphere_vertex_generator_unit_assert.svh */
// ----------------------------------------------------------------------------
// UV sphere vertex generator assertion macros
// Implication checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_GENERATOR_UNIT_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define UVS_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("uvs: same-cycle check failed");
`define UVS_ASSERT_NXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("uvs: next-cycle check failed");
`else
`define UVS_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define UVS_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

/* sv/uvs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Fixed constants, register indexes, CORDIC tables and sideband types.
// ----------------------------------------------------------------------------
package uvs_pkg;

	localparam logic [7:0] SECTOR_FLOOR = 8'd3;
	localparam logic [7:0] STACK_FLOOR  = 8'd2;
	localparam logic [7:0] MAX_SECTORS  = 8'd255;
	localparam logic [7:0] MAX_STACKS   = 8'd255;

	// dividend width of the phase and texture dividers
	localparam int DVD_W = 40;

	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_SECTOR = 2'd1;
	localparam logic [1:0] REG_STACK  = 2'd2;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;
	localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;

	localparam int ATAN_N = 24;
	localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	typedef struct packed {
		logic [15:0] vnum;
		logic [15:0] below;
		logic        upper;
		logic        lower;
	} meta_t;

	typedef struct packed {
		meta_t       meta;
		logic [16:0] tex_s;
		logic [16:0] tex_t;
	} aux_t;

endpackage

/* sv/uvs_point_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid point channel
// One word names a stack and sector index of the sphere grid.
// ----------------------------------------------------------------------------
interface uvs_point_if;
	logic       valid;
	logic       ready;
	logic [7:0] stack_index;
	logic [7:0] sector_index;

	modport source (output valid, output stack_index, output sector_index, input ready);
	modport sink (input valid, input stack_index, input sector_index, output ready);
endinterface

/* sv/uvs_vertex_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex channel
// One word carries position, normal, texture, indexes and triangle flags.
// ----------------------------------------------------------------------------
interface uvs_vertex_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] pos_x;
	logic signed [16:0] pos_y;
	logic signed [16:0] pos_z;
	logic signed [15:0] norm_x;
	logic signed [15:0] norm_y;
	logic signed [15:0] norm_z;
	logic [16:0]        tex_s;
	logic [16:0]        tex_t;
	logic [15:0]        vertex_number;
	logic [15:0]        below_number;
	logic               upper_tri_valid;
	logic               lower_tri_valid;

	modport source (
		output valid, output pos_x, output pos_y, output pos_z,
		output norm_x, output norm_y, output norm_z, output tex_s, output tex_t,
		output vertex_number, output below_number, output upper_tri_valid,
		output lower_tri_valid, input ready
	);
	modport sink (
		input valid, input pos_x, input pos_y, input pos_z,
		input norm_x, input norm_y, input norm_z, input tex_s, input tex_t,
		input vertex_number, input below_number, input upper_tri_valid,
		input lower_tri_valid, output ready
	);
endinterface

/* sv/uvs_div_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, N stages, 8-bit divisor held static by config.
// ----------------------------------------------------------------------------
module uvs_div_pipe #(
	parameter int N = 40
) (
	input  logic         clk,
	input  logic         en,
	input  logic [7:0]   den,
	input  logic [N-1:0] dvd,
	output logic [N-1:0] quo
);
	logic [7:0]   rem_s [N];
	logic [N-1:0] dvd_s [N];
	logic [N-1:0] quo_s [N];

	logic [7:0]   rem_i [N];
	logic [N-1:0] dvd_i [N];
	logic [N-1:0] quo_i [N];
	logic [7:0]   rem_n [N];
	logic [N-1:0] quo_n [N];

	always_comb begin
		rem_i[0] = '0;
		dvd_i[0] = dvd;
		quo_i[0] = '0;
		for (int k = 1; k < N; k++) begin
			rem_i[k] = rem_s[k-1];
			dvd_i[k] = dvd_s[k-1];
			quo_i[k] = quo_s[k-1];
		end
	end

	always_comb begin
		logic [8:0] trial;
		logic [8:0] diff;
		logic       ge;
		for (int k = 0; k < N; k++) begin
			trial = {rem_i[k], dvd_i[k][N-1-k]};
			diff = trial - {1'b0, den};
			ge = (trial >= {1'b0, den});
			rem_n[k] = ge ? diff[7:0] : trial[7:0];
			quo_n[k] = {quo_i[k][N-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				rem_s[k] <= rem_n[k];
				dvd_s[k] <= dvd_i[k];
				quo_s[k] <= quo_n[k];
			end
		end
	end

	assign quo = quo_s[N-1];
endmodule

/* sv/uvs_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined CORDIC sine/cosine
// Phase in Q0.32 turns to cosine and sine in Q2.30.
// ----------------------------------------------------------------------------
module uvs_cordic #(
	parameter int STAGES = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        phase,
	output logic signed [31:0] cos_v,
	output logic signed [31:0] sin_v
);
	import uvs_pkg::*;

	logic [60:0]        zprod;
	logic signed [31:0] ang_s1;
	logic [1:0]         quad_s1;

	logic signed [31:0] x_s [STAGES];
	logic signed [31:0] y_s [STAGES];
	logic signed [31:0] z_s [STAGES];
	logic [1:0]         quad_s [STAGES];

	logic signed [31:0] x_i [STAGES];
	logic signed [31:0] y_i [STAGES];
	logic signed [31:0] z_i [STAGES];
	logic [1:0]         quad_i [STAGES];
	logic signed [31:0] x_n [STAGES];
	logic signed [31:0] y_n [STAGES];
	logic signed [31:0] z_n [STAGES];

	logic signed [31:0] cos_s3;
	logic signed [31:0] sin_s3;

	// quadrant residue to radians
	assign zprod = 61'(phase[29:0]) * 61'(HALF_PI_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1 <= $signed({1'b0, zprod[60:30]});
			quad_s1 <= phase[31:30];
		end
	end

	always_comb begin
		x_i[0] = GAIN_Q30;
		y_i[0] = '0;
		z_i[0] = ang_s1;
		quad_i[0] = quad_s1;
		for (int k = 1; k < STAGES; k++) begin
			x_i[k] = x_s[k-1];
			y_i[k] = y_s[k-1];
			z_i[k] = z_s[k-1];
			quad_i[k] = quad_s[k-1];
		end
	end

	always_comb begin
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] at;
		for (int k = 0; k < STAGES; k++) begin
			dx = y_i[k] >>> k;
			dy = x_i[k] >>> k;
			at = $signed(ATAN_Q30[k]);
			if (!z_i[k][31]) begin
				x_n[k] = x_i[k] - dx;
				y_n[k] = y_i[k] + dy;
				z_n[k] = z_i[k] - at;
			end else begin
				x_n[k] = x_i[k] + dx;
				y_n[k] = y_i[k] - dy;
				z_n[k] = z_i[k] + at;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < STAGES; k++) begin
				x_s[k] <= x_n[k];
				y_s[k] <= y_n[k];
				z_s[k] <= z_n[k];
				quad_s[k] <= quad_i[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (quad_s[STAGES-1])
				QUAD_0: begin
					cos_s3 <= x_s[STAGES-1];
					sin_s3 <= y_s[STAGES-1];
				end
				QUAD_1: begin
					cos_s3 <= -y_s[STAGES-1];
					sin_s3 <= x_s[STAGES-1];
				end
				QUAD_2: begin
					cos_s3 <= -x_s[STAGES-1];
					sin_s3 <= -y_s[STAGES-1];
				end
				default: begin
					cos_s3 <= y_s[STAGES-1];
					sin_s3 <= -x_s[STAGES-1];
				end
			endcase
		end
	end

	assign cos_v = cos_s3;
	assign sin_v = sin_s3;
endmodule

/* sv/uv_sphere_vertex_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Streams one sphere vertex per grid point: position, normal, texture,
// vertex indexes and cell triangle flags.
// ----------------------------------------------------------------------------
//  port     dir  kind    word
//  point    in   stream  stack_index, sector_index
//  vertex   out  stream  position, normal, texture, indexes, flags
//  apb      in   config  radius @0x0, sector_count @0x4, stack_count @0x8
//
// One point per cycle sustained while the output word is taken. The pipeline has
// 40 stages of bit-per-stage phase division, CORDIC_STAGES + 2 for the
// CORDIC, then four product/rounding stages ending in the output register.
// Reset loads the register defaults and clears all stage valid bits.
// While the output word waits, the whole pipeline holds and point.ready
// drops; bubbles still fill as long as the output slot is free.
// ----------------------------------------------------------------------------
`include "uv_sphere_vertex_generator_unit_assert.svh"

module uv_sphere_vertex_generator_unit #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	uvs_point_if.sink   point,
	uvs_vertex_if.source vertex
);
	import uvs_pkg::*;

	localparam int COR_LAT = CORDIC_STAGES + 2;
	localparam int LAT = DVD_W + COR_LAT + 4;

	logic [15:0] radius_q;
	logic [7:0]  sector_count_q;
	logic [7:0]  stack_count_q;

	logic [7:0]  sec;
	logic [7:0]  stk;
	logic        en;
	logic [LAT-1:0] vld_q;

	// ---------------- configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd256;
			sector_count_q <= 8'd36;
			stack_count_q <= 8'd18;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_RADIUS: radius_q <= pwdata[15:0];
				REG_SECTOR: sector_count_q <= pwdata[7:0];
				REG_STACK:  stack_count_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_RADIUS: prdata = {16'd0, radius_q};
			REG_SECTOR: prdata = {24'd0, sector_count_q};
			REG_STACK:  prdata = {24'd0, stack_count_q};
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		sec = (sector_count_q < SECTOR_FLOOR) ? SECTOR_FLOOR :
			((sector_count_q > MAX_SECTORS) ? MAX_SECTORS : sector_count_q);
		stk = (stack_count_q < STACK_FLOOR) ? STACK_FLOOR :
			((stack_count_q > MAX_STACKS) ? MAX_STACKS : stack_count_q);
	end

	// ---------------- flow control
	assign en = !vld_q[LAT-1] || vertex.ready;
	assign point.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], point.valid};
		end
	end

	// ---------------- indexes and flags
	logic [7:0]  pi;
	logic [7:0]  pj;
	logic [8:0]  sec_p1;
	logic [16:0] vsum;
	logic        in_grid;
	meta_t       meta_in;

	assign pi = point.stack_index;
	assign pj = point.sector_index;

	always_comb begin
		sec_p1 = {1'b0, sec} + 9'd1;
		vsum = 17'(pi) * 17'(sec_p1) + 17'(pj);
		in_grid = (pi < stk) && (pj < sec);
		meta_in.vnum = vsum[15:0];
		meta_in.below = vsum[15:0] + 16'(sec_p1);
		meta_in.upper = in_grid && (pi != 8'd0);
		meta_in.lower = in_grid && (pi != (stk - 8'd1));
	end

	// ---------------- dividers
	logic [DVD_W-1:0] dvd_a, dvd_b, dvd_c, dvd_d;
	logic [DVD_W-1:0] quo_a, quo_b, quo_c, quo_d;

	// numerator plus half the divisor, for round to nearest
	assign dvd_a = {pj, {(DVD_W-8-7){1'b0}}, sec[7:1]};
	assign dvd_b = {{(DVD_W-31-8){1'b0}}, pi, 24'd0, stk[7:1]};
	assign dvd_c = {{(DVD_W-16-8){1'b0}}, pj, 9'd0, sec[7:1]};
	assign dvd_d = {{(DVD_W-16-8){1'b0}}, pi, 9'd0, stk[7:1]};

	uvs_div_pipe #(.N(DVD_W)) u_div_sec_ph (
		.clk(clk), .en(en), .den(sec), .dvd(dvd_a), .quo(quo_a)
	);
	uvs_div_pipe #(.N(DVD_W)) u_div_stk_ph (
		.clk(clk), .en(en), .den(stk), .dvd(dvd_b), .quo(quo_b)
	);
	uvs_div_pipe #(.N(DVD_W)) u_div_sec_tx (
		.clk(clk), .en(en), .den(sec), .dvd(dvd_c), .quo(quo_c)
	);
	uvs_div_pipe #(.N(DVD_W)) u_div_stk_tx (
		.clk(clk), .en(en), .den(stk), .dvd(dvd_d), .quo(quo_d)
	);

	meta_t meta_pipe [DVD_W];

	always_ff @(posedge clk) begin
		if (en) begin
			meta_pipe[0] <= meta_in;
			for (int k = 1; k < DVD_W; k++) meta_pipe[k] <= meta_pipe[k-1];
		end
	end

	// ---------------- CORDIC
	logic [31:0]        ph_stk;
	logic signed [31:0] cst, sst, cse, sse;
	aux_t               aux_in;

	// stack angle starts at a quarter turn and descends
	assign ph_stk = 32'h4000_0000 - quo_b[31:0];

	always_comb begin
		aux_in.meta = meta_pipe[DVD_W-1];
		aux_in.tex_s = (quo_c > DVD_W'(65536)) ? 17'h10000 : quo_c[16:0];
		aux_in.tex_t = (quo_d > DVD_W'(65536)) ? 17'h10000 : quo_d[16:0];
	end

	uvs_cordic #(.STAGES(CORDIC_STAGES)) u_cor_stk (
		.clk(clk), .en(en), .phase(ph_stk), .cos_v(cst), .sin_v(sst)
	);
	uvs_cordic #(.STAGES(CORDIC_STAGES)) u_cor_sec (
		.clk(clk), .en(en), .phase(quo_a[31:0]), .cos_v(cse), .sin_v(sse)
	);

	aux_t aux_pipe [COR_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			aux_pipe[0] <= aux_in;
			for (int k = 1; k < COR_LAT; k++) aux_pipe[k] <= aux_pipe[k-1];
		end
	end

	// ---------------- products and rounding
	logic signed [63:0] pxx_s1, pxy_s1;
	logic signed [31:0] sz_s1;
	aux_t               aux_s1;
	logic signed [31:0] nx_s2, ny_s2, sz_s2;
	aux_t               aux_s2;
	logic signed [48:0] px_s3, py_s3, pz_s3;
	logic signed [15:0] nx_s3, ny_s3, nz_s3;
	aux_t               aux_s3;
	logic signed [16:0] px_s4, py_s4, pz_s4;
	logic signed [15:0] nx_s4, ny_s4, nz_s4;
	aux_t               aux_s4;

	logic signed [63:0] rx, ry;
	logic signed [16:0] rad_sg;

	function automatic logic signed [15:0] to_norm(input logic signed [31:0] q);
		logic signed [32:0] t;
		t = (33'(q) + 33'sd16384) >>> 15;
		if (t > 33'sd32767) return 16'sh7FFF;
		if (t < -33'sd32768) return 16'sh8000;
		return t[15:0];
	endfunction

	function automatic logic signed [16:0] to_pos(input logic signed [48:0] p);
		logic signed [48:0] t;
		t = (p + 49'sd536870912) >>> 30;
		if (t > 49'sd65535) return 17'sd65535;
		if (t < -49'sd65535) return -17'sd65535;
		return t[16:0];
	endfunction

	always_comb begin
		rx = (pxx_s1 + 64'sd536870912) >>> 30;
		ry = (pxy_s1 + 64'sd536870912) >>> 30;
		rad_sg = $signed({1'b0, radius_q});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s1 <= 64'(cst) * 64'(cse);
			pxy_s1 <= 64'(cst) * 64'(sse);
			sz_s1 <= sst;
			aux_s1 <= aux_pipe[COR_LAT-1];

			nx_s2 <= rx[31:0];
			ny_s2 <= ry[31:0];
			sz_s2 <= sz_s1;
			aux_s2 <= aux_s1;

			px_s3 <= 49'(rad_sg) * 49'(nx_s2);
			py_s3 <= 49'(rad_sg) * 49'(ny_s2);
			pz_s3 <= 49'(rad_sg) * 49'(sz_s2);
			nx_s3 <= to_norm(nx_s2);
			ny_s3 <= to_norm(ny_s2);
			nz_s3 <= to_norm(sz_s2);
			aux_s3 <= aux_s2;

			px_s4 <= to_pos(px_s3);
			py_s4 <= to_pos(py_s3);
			pz_s4 <= to_pos(pz_s3);
			nx_s4 <= nx_s3;
			ny_s4 <= ny_s3;
			nz_s4 <= nz_s3;
			aux_s4 <= aux_s3;
		end
	end

	// ---------------- output word
	assign vertex.valid = vld_q[LAT-1];
	assign vertex.pos_x = px_s4;
	assign vertex.pos_y = py_s4;
	assign vertex.pos_z = pz_s4;
	assign vertex.norm_x = nx_s4;
	assign vertex.norm_y = ny_s4;
	assign vertex.norm_z = nz_s4;
	assign vertex.tex_s = aux_s4.tex_s;
	assign vertex.tex_t = aux_s4.tex_t;
	assign vertex.vertex_number = aux_s4.meta.vnum;
	assign vertex.below_number = aux_s4.meta.below;
	assign vertex.upper_tri_valid = aux_s4.meta.upper;
	assign vertex.lower_tri_valid = aux_s4.meta.lower;

	// ---------------- checks
	`UVS_ASSERT_IMP(a_ready_low_only_when_full, clk, arst_n, !point.ready, vld_q[LAT-1])
	`UVS_ASSERT_NXT(a_stall_holds_pipe, clk, arst_n, vld_q[LAT-1] && !vertex.ready, $stable(vld_q))
	`UVS_ASSERT_NXT(a_accept_enters_pipe, clk, arst_n, point.valid && point.ready, vld_q[0])
	`UVS_ASSERT_IMP(a_tri_inside_grid, clk, arst_n, vertex.valid && (vertex.upper_tri_valid || vertex.lower_tri_valid), (vertex.tex_s < 17'h10000) && (vertex.tex_t < 17'h10000))
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere vertex generator testbench
// Writes radius and grid counts over APB, streams grid points with random
// gaps and output stalls, and checks every vertex word against a CORDIC
// based predictor. A short table of directed points runs first.
// ----------------------------------------------------------------------------
module tb_top;
	import uvs_pkg::*;

	// register slot past the last one; writes there are ignored
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic signed [16:0] pos_x, pos_y, pos_z;
		logic signed [15:0] norm_x, norm_y, norm_z;
		logic [16:0]        tex_s, tex_t;
		logic [15:0]        vnum, below;
		logic               upper, lower;
	} vtx_t;

	typedef struct {
		logic [7:0] stk, sec;
		logic       known;
		logic [15:0] vnum;
		logic        upper, lower;
	} pt_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          errors = 0;
	bit          calm = 1'b0;

	uvs_point_if  point ();
	uvs_vertex_if vertex ();

	uv_sphere_vertex_generator_unit dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.point(point.sink), .vertex(vertex.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the registers
	logic [15:0] radius_q = 16'd256;
	logic [7:0]  sectors_q = 8'd36;
	logic [7:0]  stacks_q = 8'd18;
	vtx_t        vertex_fifo[$];

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic void cordic_trig(logic [31:0] phase, output longint c, output longint s);
		longint x, y, z, dx, dy, r;
		r = phase[29:0];
		z = (r * longint'(HALF_PI_Q30)) >>> 30;
		x = GAIN_Q30;
		y = 0;
		for (int k = 0; k < 16; k++) begin
			dx = shr_floor(y, k);
			dy = shr_floor(x, k);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_Q30[k]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_Q30[k]);
			end
		end
		case (phase[31:30])
			QUAD_0: begin c = x; s = y; end
			QUAD_1: begin c = -y; s = x; end
			QUAD_2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [16:0] tex_ratio(longint num, longint den);
		longint v;
		v = ((num << 16) + den / 2) / den;
		return v > 65536 ? 17'd65536 : 17'(v);
	endfunction

	function automatic vtx_t vertex_of(logic [7:0] i8, logic [7:0] j8);
		vtx_t   v;
		longint i, j, sec, stk, cst, sst, cse, sse, nx, ny;
		logic [31:0] ph_sec, ph_stk;
		logic [15:0] vn;
		bit in_grid;
		i = i8; j = j8;
		sec = sectors_q < SECTOR_FLOOR ? 3 : sectors_q;
		stk = stacks_q < STACK_FLOOR ? 2 : stacks_q;
		ph_sec = 32'(((j << 32) + sec / 2) / sec);
		ph_stk = 32'((64'd1 << 30) - (((i << 31) + stk / 2) / stk));
		cordic_trig(ph_stk, cst, sst);
		cordic_trig(ph_sec, cse, sse);
		nx = (cst * cse + (64'sd1 <<< 29)) >>> 30;
		ny = (cst * sse + (64'sd1 <<< 29)) >>> 30;
		v.pos_x = 17'(clip((longint'(radius_q) * nx + (64'sd1 <<< 29)) >>> 30, -65535, 65535));
		v.pos_y = 17'(clip((longint'(radius_q) * ny + (64'sd1 <<< 29)) >>> 30, -65535, 65535));
		v.pos_z = 17'(clip((longint'(radius_q) * sst + (64'sd1 <<< 29)) >>> 30, -65535, 65535));
		v.norm_x = 16'(clip((nx + 16384) >>> 15, -32768, 32767));
		v.norm_y = 16'(clip((ny + 16384) >>> 15, -32768, 32767));
		v.norm_z = 16'(clip((sst + 16384) >>> 15, -32768, 32767));
		v.tex_s = tex_ratio(j, sec);
		v.tex_t = tex_ratio(i, stk);
		vn = 16'(i * (sec + 1) + j);
		v.vnum = vn;
		v.below = 16'(vn + sec + 1);
		in_grid = (i < stk) && (j < sec);
		v.upper = in_grid && i != 0;
		v.lower = in_grid && i != stk - 1;
		return v;
	endfunction

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_RADIUS: radius_q = val[15:0];
			REG_SECTOR: sectors_q = val[7:0];
			REG_STACK:  stacks_q = val[7:0];
			default: ;
		endcase
	endtask

	task automatic send_point(logic [7:0] i, logic [7:0] j);
		while (!calm && $urandom_range(99) < 8) begin
			point.valid <= 1'b0;
			@(posedge clk);
		end
		point.valid <= 1'b1;
		point.stack_index <= i;
		point.sector_index <= j;
		vertex_fifo = {vertex_fifo, vertex_of(i, j)};
		do @(posedge clk); while (!point.ready);
	endtask

	task automatic drain();
		point.valid <= 1'b0;
		while (vertex_fifo.size() != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	// output side
	initial vertex.ready = 1'b0;
	always @(posedge clk) begin
		vtx_t e;
		if (vertex.valid && vertex.ready) begin
			if (vertex_fifo.size() == 0) begin
				$error("vertex word with nothing expected");
				errors++;
			end else begin
				e = vertex_fifo.pop_front();
				if (vertex.pos_x !== e.pos_x) begin
					$error("pos_x exp %0d got %0d", e.pos_x, vertex.pos_x); errors++; end
				if (vertex.pos_y !== e.pos_y) begin
					$error("pos_y exp %0d got %0d", e.pos_y, vertex.pos_y); errors++; end
				if (vertex.pos_z !== e.pos_z) begin
					$error("pos_z exp %0d got %0d", e.pos_z, vertex.pos_z); errors++; end
				if (vertex.norm_x !== e.norm_x) begin
					$error("norm_x exp %0d got %0d", e.norm_x, vertex.norm_x); errors++; end
				if (vertex.norm_y !== e.norm_y) begin
					$error("norm_y exp %0d got %0d", e.norm_y, vertex.norm_y); errors++; end
				if (vertex.norm_z !== e.norm_z) begin
					$error("norm_z exp %0d got %0d", e.norm_z, vertex.norm_z); errors++; end
				if (vertex.tex_s !== e.tex_s) begin
					$error("tex_s exp %0d got %0d", e.tex_s, vertex.tex_s); errors++; end
				if (vertex.tex_t !== e.tex_t) begin
					$error("tex_t exp %0d got %0d", e.tex_t, vertex.tex_t); errors++; end
				if (vertex.vertex_number !== e.vnum) begin
					$error("vertex_number exp %0d got %0d", e.vnum, vertex.vertex_number);
					errors++;
				end
				if (vertex.below_number !== e.below) begin
					$error("below_number exp %0d got %0d", e.below, vertex.below_number);
					errors++;
				end
				if (vertex.upper_tri_valid !== e.upper) begin
					$error("upper_tri_valid exp %0b got %0b", e.upper, vertex.upper_tri_valid);
					errors++;
				end
				if (vertex.lower_tri_valid !== e.lower) begin
					$error("lower_tri_valid exp %0b got %0b", e.lower, vertex.lower_tri_valid);
					errors++;
				end
			end
		end
		vertex.ready <= calm || ($urandom_range(99) >= 8);
	end

	// directed points at reset settings (36 sectors, 18 stacks);
	// index fields are typed only where read off at a glance
	pt_row_t directed [12] = '{
		'{8'd0,   8'd0,   1'b1, 16'd0,   1'b0, 1'b1},
		'{8'd1,   8'd0,   1'b1, 16'd37,  1'b1, 1'b1},
		'{8'd17,  8'd35,  1'b1, 16'd664, 1'b1, 1'b0},
		'{8'd18,  8'd36,  1'b1, 16'd702, 1'b0, 1'b0},
		'{8'd9,   8'd9,   1'b0, 16'd0,   1'b0, 1'b0},
		'{8'd9,   8'd18,  1'b0, 16'd0,   1'b0, 1'b0},
		'{8'd4,   8'd27,  1'b0, 16'd0,   1'b0, 1'b0},
		'{8'd255, 8'd255, 1'b0, 16'd0,   1'b0, 1'b0},
		'{8'd0,   8'd255, 1'b0, 16'd0,   1'b0, 1'b0},
		'{8'd255, 8'd0,   1'b0, 16'd0,   1'b0, 1'b0},
		'{8'd170, 8'd85,  1'b0, 16'd0,   1'b0, 1'b0},
		'{8'd85,  8'd170, 1'b0, 16'd0,   1'b0, 1'b0}
	};

	task automatic random_phase(int n);
		logic [7:0] i, j;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(9) == 0) begin
				i = 8'($urandom); j = 8'($urandom);
			end else begin
				i = 8'($urandom_range(stacks_q < 2 ? 2 : stacks_q));
				j = 8'($urandom_range(sectors_q < 3 ? 3 : sectors_q));
			end
			send_point(i, j);
		end
	endtask

	initial begin
		vtx_t e;
		point.valid = 1'b0;
		point.stack_index = '0;
		point.sector_index = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[n]) begin
			if (directed[n].known) begin
				e = vertex_of(directed[n].stk, directed[n].sec);
				if (e.vnum !== directed[n].vnum) begin
					$error("vertex_number exp %0d got %0d", directed[n].vnum, e.vnum);
					errors++;
				end
				if (e.upper !== directed[n].upper) begin
					$error("upper_tri_valid exp %0b got %0b", directed[n].upper, e.upper);
					errors++;
				end
				if (e.lower !== directed[n].lower) begin
					$error("lower_tri_valid exp %0b got %0b", directed[n].lower, e.lower);
					errors++;
				end
			end
			send_point(directed[n].stk, directed[n].sec);
		end
		drain();
		// zero radius, counts below floor
		reg_write(REG_RADIUS, 32'd0);
		reg_write(REG_SECTOR, 32'd0);
		reg_write(REG_STACK, 32'd1);
		send_point(8'd0, 8'd0);
		send_point(8'd1, 8'd2);
		send_point(8'd2, 8'd3);
		random_phase(40);
		drain();
		// largest radius and counts, no idling
		reg_write(REG_RADIUS, 32'hFFFF);
		reg_write(REG_SECTOR, 32'd255);
		reg_write(REG_STACK, 32'd255);
		calm = 1'b1;
		random_phase(250);
		calm = 1'b0;
		drain();
		reg_write(REG_UNUSED, 32'h1234);
		for (int p = 0; p < 5; p++) begin
			reg_write(REG_RADIUS, $urandom);
			reg_write(REG_SECTOR, $urandom_range(255));
			reg_write(REG_STACK, $urandom_range(255));
			random_phase(150);
			drain();
		end
		if (errors == 0)
			$display("uv_sphere_vertex_generator_unit regression: pass");
		else
			$display("uv_sphere_vertex_generator_unit regression: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("uv_sphere_vertex_generator_unit regression: fail");
		$finish;
	end
endmodule

/* uv_sphere_vertex_generator_unit.f */
+incdir+sv
sv/uvs_pkg.sv
sv/uvs_point_if.sv
sv/uvs_vertex_if.sv
sv/uvs_div_pipe.sv
sv/uvs_cordic.sv
sv/uv_sphere_vertex_generator_unit.sv
sim/tb_top.sv
